### design/split_array_deque_core_defines.svh
// ----------------------------------------------------------------------------
// split_array_deque_core_defines
// assertion macros shared by the deque checker
// ----------------------------------------------------------------------------
`ifndef SPLIT_ARRAY_DEQUE_CORE_DEFINES_SVH
`define SPLIT_ARRAY_DEQUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while reset is held
`define SAD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, sampled on clk, off while reset is held
`define SAD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

### design/sad_pkg.sv
// ----------------------------------------------------------------------------
// sad_pkg
// operation and status codes and the control record of the split array deque
// ----------------------------------------------------------------------------
package sad_pkg;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_INJECT = 2'd2,
		OP_EJECT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam int unsigned DataW = 32;

	// decision for one request, handed from the pointer unit to the datapath
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} mem_req_t;

endpackage

### design/sad_ram.sv
// ----------------------------------------------------------------------------
// sad_ram
// generic single-clock ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sad_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/sad_ctrl.sv
// ----------------------------------------------------------------------------
// sad_ctrl
// end pointers of the deque and the per-request decision
// ----------------------------------------------------------------------------
module sad_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  sad_pkg::op_t             op_s1,
	output sad_pkg::mem_req_t        req,
	output logic [$clog2(DEPTH)-1:0] addr
);

	localparam int unsigned PtrW  = $clog2(DEPTH + 1);
	localparam int unsigned AddrW = $clog2(DEPTH);
	localparam logic [PtrW-1:0] PtrMid  = PtrW'(DEPTH / 2);
	localparam logic [PtrW-1:0] PtrTop  = PtrW'(DEPTH);
	localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);

	logic [PtrW-1:0] upper_q;
	logic [PtrW-1:0] lower_q;
	logic [PtrW-1:0] upper_dec;
	logic [PtrW-1:0] lower_dec;
	logic            empty;

	assign empty     = (upper_q == lower_q);
	assign upper_dec = upper_q - PtrOne;
	assign lower_dec = lower_q - PtrOne;

	always_comb begin
		req.wr_en  = 1'b0;
		req.rd_en  = 1'b0;
		req.status = sad_pkg::ST_DONE;
		addr       = upper_q[AddrW-1:0];
		case (op_s1)
			sad_pkg::OP_PUSH: begin
				addr = upper_q[AddrW-1:0];
				if (upper_q < PtrTop) begin
					req.wr_en = valid_s1;
				end else begin
					req.status = sad_pkg::ST_FULL;
				end
			end
			sad_pkg::OP_POP: begin
				addr = upper_dec[AddrW-1:0];
				if (!empty) begin
					req.rd_en = valid_s1;
				end else begin
					req.status = sad_pkg::ST_EMPTY;
				end
			end
			sad_pkg::OP_INJECT: begin
				addr = lower_dec[AddrW-1:0];
				if (lower_q != '0) begin
					req.wr_en = valid_s1;
				end else begin
					req.status = sad_pkg::ST_FULL;
				end
			end
			default: begin
				addr = lower_q[AddrW-1:0];
				if (!empty) begin
					req.rd_en = valid_s1;
				end else begin
					req.status = sad_pkg::ST_EMPTY;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= PtrMid;
			lower_q <= PtrMid;
		end else begin
			if ((req.wr_en || req.rd_en) && (op_s1 == sad_pkg::OP_PUSH)) begin
				upper_q <= upper_q + PtrOne;
			end
			if ((req.wr_en || req.rd_en) && (op_s1 == sad_pkg::OP_POP)) begin
				upper_q <= upper_dec;
			end
			if ((req.wr_en || req.rd_en) && (op_s1 == sad_pkg::OP_INJECT)) begin
				lower_q <= lower_dec;
			end
			if ((req.wr_en || req.rd_en) && (op_s1 == sad_pkg::OP_EJECT)) begin
				lower_q <= lower_q + PtrOne;
			end
		end
	end

endmodule

### design/split_array_deque_core.sv
// ----------------------------------------------------------------------------
// split_array_deque_core
// double-ended queue in a fixed, non-wrapping array, one request per cycle
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------
//  request  | start, busy         | operation, value_in
//  result   | done (one cycle)    | status, value_out
//
//  a request is taken at every edge where start is high; busy stays low
//  each result shows up once its request has passed stage 1 and stage 2, one result per request
//  stage 1 registers the request, compares the end pointers and drives the ram
//  stage 2 holds the status while the ram returns the removed entry
//  reset clears the pointers to the middle of the array; the store is not cleared
//  the receiver cannot stall: done lasts exactly one cycle
//
module split_array_deque_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value_in,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] value_out
);

	localparam int unsigned AddrW = $clog2(DEPTH);

	// stage 1: registered request
	logic                         valid_s1;
	sad_pkg::op_t                 op_s1;
	logic [sad_pkg::DataW-1:0]    data_s1;

	// decision from the pointer unit
	sad_pkg::mem_req_t            req;
	logic [AddrW-1:0]             addr;

	// stage 2: result being shown
	logic                         valid_s2;
	logic                         rd_s2;
	sad_pkg::status_t             status_s2;
	logic [sad_pkg::DataW-1:0]    rdata;

	// nothing in the pipe ever waits, so requests are always welcome
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		op_s1     <= sad_pkg::op_t'(operation);
		data_s1   <= value_in;
		rd_s2     <= req.rd_en;
		status_s2 <= req.status;
	end

	sad_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.req      (req),
		.addr     (addr)
	);

	// single address serves both write and read, only one happens per request
	sad_ram #(
		.WIDTH (sad_pkg::DataW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (addr),
		.wdata (data_s1),
		.re    (req.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	assign done      = valid_s2;
	assign status    = status_s2;
	// removed value only for a successful pop or eject, zero otherwise
	assign value_out = rd_s2 ? $signed(rdata) : '0;

endmodule

### design/sad_checker.sv
// ----------------------------------------------------------------------------
// sad_checker
// port-level checks on the split array deque
// ----------------------------------------------------------------------------
`include "split_array_deque_core_defines.svh"

module sad_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         operation,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [31:0] value_out
);

	logic taken;
	logic shown_empty;
	logic shown_full;

	assign taken       = start && !busy;
	assign shown_empty = done && (status == sad_pkg::ST_EMPTY);
	assign shown_full  = done && (status == sad_pkg::ST_FULL);

	function automatic logic is_removal(logic [1:0] op);
		return (op == sad_pkg::OP_POP) || (op == sad_pkg::OP_EJECT);
	endfunction

	function automatic logic is_insertion(logic [1:0] op);
		return (op == sad_pkg::OP_PUSH) || (op == sad_pkg::OP_INJECT);
	endfunction

	// every answer belongs to an accepted request, and nothing else raises done
	`SAD_ASSERT_NOW(a_answer_follows, done, $past(taken, 2))
	// refused requests never return data
	`SAD_ASSERT_NOW(a_refused_zero, done && (status != sad_pkg::ST_DONE), value_out == '0)
	// empty only ever reported for removals
	`SAD_ASSERT_NOW(a_empty_on_remove, shown_empty, is_removal($past(operation, 2)))
	// full only ever reported for insertions
	`SAD_ASSERT_NOW(a_full_on_insert, shown_full, is_insertion($past(operation, 2)))
	// every taken request is followed by its answer once it has passed both stages
	`SAD_ASSERT_NEXT(a_answer_due, taken, ##1 done)

endmodule

bind split_array_deque_core sad_checker u_sad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.done      (done),
	.status    (status),
	.value_out (value_out)
);
